// ===== src/u8cd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8cd_pkg
// Shared types, length codes, a length classifier and a merge helper for the utf-8 code point decoder.
// ----------------------------------------------------------------------------
package u8cd_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    // sequence length codes
    localparam logic [2:0] LEN_SKIP  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // number of results one byte causes
    localparam logic [1:0] NRES_NONE = 2'd0;
    localparam logic [1:0] NRES_ONE  = 2'd1;
    localparam logic [1:0] NRES_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]      count;
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
    } u8cd_entry_t;

    function automatic logic [2:0] seq_len_of(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        len = LEN_SKIP;
        if (b[7] == 1'b0)
        begin
            len = LEN_ONE;
        end
        else if (b[7:5] == 3'b110)
        begin
            len = LEN_TWO;
        end
        else if (b[7:4] == 4'b1110)
        begin
            len = LEN_THREE;
        end
        else if (b[7:3] == 5'b11110)
        begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] merge_cp(
        input logic [BYTE_W-1:0] s0,
        input logic [BYTE_W-1:0] s1,
        input logic [BYTE_W-1:0] s2,
        input logic [BYTE_W-1:0] s3,
        input logic [2:0]        len
    );
        logic [CP_W-1:0] cp;
        case (len)
            LEN_TWO:   cp = {10'd0, s0[4:0], s1[5:0]};
            LEN_THREE: cp = {5'd0, s0[3:0], s1[5:0], s2[5:0]};
            LEN_FOUR:  cp = {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
            default:   cp = {13'd0, s0};
        endcase
        return cp;
    endfunction

endpackage

// ===== src/u8cd_front.sv =====
// ----------------------------------------------------------------------------
// u8cd_front
// Byte classifier: tracks the open sequence and forms up to two code points
// for each accepted byte.
// ----------------------------------------------------------------------------
module u8cd_front
    import u8cd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              string_end,
    output logic              push,
    output u8cd_entry_t       entry
);

    logic [BYTE_W-1:0] held_reg [3];
    logic [1:0]        held_count_reg;
    logic [1:0]        held_count_next;
    logic [2:0]        seq_len_reg;
    logic [2:0]        seq_len_next;
    logic              hold_write;
    logic [1:0]        hold_index;

    logic [2:0]        len_b;
    logic [2:0]        len_s0;
    logic [BYTE_W-1:0] s0;
    logic [BYTE_W-1:0] s1;
    logic [BYTE_W-1:0] s2;
    logic              complete;

    always_comb
    begin
        len_b    = seq_len_of(text_byte);
        s1       = (held_count_reg == 2'd1) ? text_byte : held_reg[1];
        s2       = (held_count_reg == 2'd2) ? text_byte : held_reg[2];
        // tail after dropping the lead: one or two bytes, last one is text_byte
        s0       = (held_count_reg == 2'd1) ? text_byte : held_reg[1];
        len_s0   = seq_len_of(s0);
        complete = ({1'b0, held_count_reg} + 3'd1) >= seq_len_reg;

        entry.count     = NRES_NONE;
        entry.cp0       = '0;
        entry.cp1       = {13'd0, text_byte};
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        hold_write      = 1'b0;
        hold_index      = held_count_reg;

        if (seq_len_reg == LEN_SKIP)
        begin
            if (len_b == LEN_ONE)
            begin
                entry.count = NRES_ONE;
                entry.cp0   = {13'd0, text_byte};
            end
            else if (len_b != LEN_SKIP && !string_end)
            begin
                hold_write      = 1'b1;
                hold_index      = 2'd0;
                held_count_next = 2'd1;
                seq_len_next    = len_b;
            end
        end
        else if (complete)
        begin
            entry.count     = NRES_ONE;
            entry.cp0       = merge_cp(held_reg[0], s1, s2, text_byte, seq_len_reg);
            held_count_next = 2'd0;
            seq_len_next    = LEN_SKIP;
        end
        else if (string_end)
        begin
            // lead dropped, remaining bytes decoded again
            if (held_count_reg == 2'd1)
            begin
                if (len_b == LEN_ONE)
                begin
                    entry.count = NRES_ONE;
                    entry.cp0   = {13'd0, text_byte};
                end
            end
            else if (len_s0 == LEN_ONE)
            begin
                entry.cp0   = {13'd0, s0};
                entry.count = (len_b == LEN_ONE) ? NRES_TWO : NRES_ONE;
            end
            else if (len_s0 == LEN_TWO)
            begin
                entry.count = NRES_ONE;
                entry.cp0   = merge_cp(s0, text_byte, text_byte, text_byte, LEN_TWO);
            end
            else if (len_b == LEN_ONE)
            begin
                entry.count = NRES_ONE;
                entry.cp0   = {13'd0, text_byte};
            end
            held_count_next = 2'd0;
            seq_len_next    = LEN_SKIP;
        end
        else
        begin
            hold_write      = 1'b1;
            held_count_next = held_count_reg + 2'd1;
        end

        if (string_end)
        begin
            held_count_next = 2'd0;
            seq_len_next    = LEN_SKIP;
        end
    end

    assign push = accept && (entry.count != NRES_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= LEN_SKIP;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_write)
        begin
            held_reg[hold_index] <= text_byte;
        end
    end

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == LEN_SKIP) == (held_count_reg == 2'd0))
        else $error("held count and sequence length disagree");

    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != LEN_SKIP) |-> ({1'b0, held_count_reg} < seq_len_reg))
        else $error("held count reached sequence length");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && string_end) |=> (seq_len_reg == LEN_SKIP))
        else $error("sequence left open after string end");

endmodule

// ===== src/u8cd_queue.sv =====
// ----------------------------------------------------------------------------
// u8cd_queue
// Small fifo of decoded entries between the classifier and the output stage.
// ----------------------------------------------------------------------------
module u8cd_queue
    import u8cd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  u8cd_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output u8cd_entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8cd_entry_t      store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

// ===== src/u8cd_back.sv =====
// ----------------------------------------------------------------------------
// u8cd_back
// Output stage: hands out the one or two code points of the head entry.
// ----------------------------------------------------------------------------
module u8cd_back
    import u8cd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  u8cd_entry_t     head,
    output logic            pop,
    output logic            cp_valid,
    input  logic            cp_ready,
    output logic [CP_W-1:0] code_point,
    output logic            run_end
);

    logic idx_reg;
    logic idx_next;
    logic last;

    assign last       = idx_reg || (head.count == NRES_ONE);
    assign cp_valid   = head_valid;
    assign code_point = idx_reg ? head.cp1 : head.cp0;
    assign run_end    = last;
    assign pop        = head_valid && cp_ready && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (head_valid && cp_ready)
        begin
            idx_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_second_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg |-> (head_valid && head.count == NRES_TWO))
        else $error("second result without a two-result entry");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && cp_ready && !last) |=> idx_reg)
        else $error("second result skipped");

endmodule

// ===== src/utf8_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Takes one utf-8 byte per transfer and gives unvalidated 21-bit code points.
// ----------------------------------------------------------------------------
// a completed code point is registered in the entry queue and offered from its head.
// throughput: one byte per cycle while the entry queue is not full; a byte with two
//   results holds the output for both code points, drained by the single output port.
// the entry queue is QUEUE_DEPTH deep; byte_ready drops only when it is full.
// reset clears the open sequence and the queue; held bytes are not cleared.
module utf8_codepoint_decoder
    import u8cd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              string_end,
    output logic              cp_valid,
    input  logic              cp_ready,
    output logic [CP_W-1:0]   code_point,
    output logic              run_end
);

    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        not_empty;
    u8cd_entry_t entry;
    u8cd_entry_t head;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    u8cd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_byte),
        .string_end (string_end),
        .push       (push),
        .entry      (entry)
    );

    u8cd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    u8cd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .code_point (code_point),
        .run_end    (run_end)
    );

endmodule
